>>> hw/rtl/sccm_pkg.sv
// ----------------------------------------------------------------------------
// sccm_pkg: shared types and constants of the sparse matrix multiplier
// Holds the transaction payload structs, the item and status codes and the
// sizes of the entry stores.
// ----------------------------------------------------------------------------
package sccm_pkg;

  localparam int MaxDim  = 32;
  localparam int MaxNnz  = 256;
  localparam int DimW    = 6;                    // holds 0..MaxDim
  localparam int IdxW    = 5;                    // row or column index
  localparam int CntW    = $clog2(MaxNnz + 1);   // entry count, 0..MaxNnz
  localparam int AddrW   = $clog2(MaxNnz);       // entry store address
  localparam int ValW    = 16;
  localparam int ProdW   = 2 * ValW;
  localparam int SumW    = 40;
  localparam int CfgIdxW = 2;

  typedef enum logic [1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_RUN    = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_ORDER = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  localparam logic [CfgIdxW-1:0] CFG_A_ROWS    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_B_COLS    = 2'd2;

  typedef struct packed {
    logic [1:0]             kind;
    logic [IdxW-1:0]        row;
    logic [IdxW-1:0]        col;
    logic signed [ValW-1:0] value;
  } item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [IdxW-1:0]        out_row;
    logic [IdxW-1:0]        out_col;
    logic signed [SumW-1:0] out_value;
    logic                   last;
    logic                   empty_res;
  } result_t;

endpackage

>>> hw/rtl/sparse_csr_matrix_multiply_top.sv
// ----------------------------------------------------------------------------
// sparse_csr_matrix_multiply_top: sparse matrix multiply C = A * B
// Entry stores for A and B, a column-major copy of B, and a small sequencer
// that merges one A row with every B column through one multiply-accumulate.
// ----------------------------------------------------------------------------
// Use: load the nonzero entries of A (kind 0) and B (kind 1) in strictly
// increasing (row, col) order; each load transaction answers with one status
// result (ok, index out of range, out of order, store full), and a rejected
// load changes nothing. A run transaction (kind 2) names one row of C and
// yields its nonzero entries in ascending column order, the final one flagged
// last, or a single result flagged empty_res. A clear transaction (kind 3)
// empties both stores. Values are signed Q8.8; sums are Q24.16 saturated to
// 40 bits after every addition. The block takes one item at a time: item_ready
// is high only while the sequencer is idle. A run of a row beyond a_rows answers
// with a range status. An accepted A load that opens a new row first fills the
// row starts from the row after that of the previous A load (row 0 for the
// first A load after a clear) up to its own row. A run merges each of the b_cols
// columns in turn through the single compare and multiply-accumulate unit. The
// first run after B changed first rebuilds the column copy of B, scanning the B
// store for every column with one registered read per entry. A finished result
// that waits for the result slot stalls the sequencer. Configuration writes are
// always accepted and must be made while the block is idle.
// ----------------------------------------------------------------------------
module sparse_csr_matrix_multiply_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  sccm_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output sccm_pkg::result_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sccm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [sccm_pkg::DimW-1:0]     cfg_data
);
  import sccm_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_AFILL  = 16'h0002,
    S_EMIT   = 16'h0004,
    S_TR_COL = 16'h0008,
    S_TR_RD  = 16'h0010,
    S_TR_CHK = 16'h0020,
    S_RS0    = 16'h0040,
    S_RS1    = 16'h0080,
    S_RS2    = 16'h0100,
    S_COL0   = 16'h0200,
    S_COL1   = 16'h0400,
    S_COL2   = 16'h0800,
    S_MRD    = 16'h1000,
    S_MCMP   = 16'h2000,
    S_MACC   = 16'h4000,
    S_CEND   = 16'h8000
  } state_t;

  localparam logic signed [SumW:0] SumMax = {2'b00, {(SumW-1){1'b1}}};
  localparam logic signed [SumW:0] SumMin = {2'b11, {(SumW-1){1'b0}}};

  // Entry stores. Row starts of A and column starts of the B copy live in
  // small memories as well.
  logic signed [ValW-1:0] a_val_mem  [MaxNnz];
  logic [IdxW-1:0]        a_col_mem  [MaxNnz];
  logic signed [ValW-1:0] b_val_mem  [MaxNnz];
  logic [IdxW-1:0]        b_row_mem  [MaxNnz];
  logic [IdxW-1:0]        b_col_mem  [MaxNnz];
  logic signed [ValW-1:0] bt_val_mem [MaxNnz];
  logic [IdxW-1:0]        bt_row_mem [MaxNnz];
  logic [CntW-1:0]        a_start_mem  [MaxDim+1];
  logic [CntW-1:0]        bt_start_mem [MaxDim+1];

  state_t state;

  logic [DimW-1:0] a_rows, inner_dim, b_cols;
  logic [DimW-1:0] nr, nk, nc;

  logic [CntW-1:0] a_count, b_count;
  logic            a_pos_valid, b_pos_valid;
  logic [2*IdxW-1:0] last_a_pos, last_b_pos;
  logic            transpose_ready;

  // Sequencer working registers.
  logic [IdxW-1:0] run_row;
  logic [DimW-1:0] fill_k;
  logic [IdxW-1:0] fill_end;
  logic [CntW-1:0] fill_v;
  logic [DimW-1:0] tr_col;
  logic [CntW-1:0] tr_i;
  logic [CntW-1:0] tr_wp;
  logic [CntW-1:0] a_beg, a_end, pa, pb, b_end;
  logic [IdxW-1:0] col_j;
  logic signed [ProdW-1:0] prod;
  logic signed [SumW-1:0]  sum;
  logic            have_held;
  result_t         res;

  // Registered read data.
  logic signed [ValW-1:0] a_val_rd, b_val_rd, bt_val_rd;
  logic [IdxW-1:0]        a_col_rd, b_row_rd, b_col_rd, bt_row_rd;
  logic [CntW-1:0]        a_start_rd, bt_start_rd;

  // Saturate a configured dimension to 1..MaxDim.
  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v);
    if (v == '0) return DimW'(1);
    if (v > DimW'(MaxDim)) return DimW'(MaxDim);
    return v;
  endfunction

  assign nr = eff_dim(a_rows);
  assign nk = eff_dim(inner_dim);
  assign nc = eff_dim(b_cols);

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;

  // Load checks, evaluated on the item at the input.
  logic              is_a;
  logic [DimW-1:0]   lim_r, lim_c;
  logic [2*IdxW-1:0] pos;
  logic              bad_range, bad_order, bad_full;

  always_comb begin
    is_a      = (item.kind == KIND_LOAD_A);
    lim_r     = is_a ? nr : nk;
    lim_c     = is_a ? nk : nc;
    pos       = {item.row, item.col};
    bad_range = ({1'b0, item.row} >= lim_r) || ({1'b0, item.col} >= lim_c);
    bad_order = is_a ? (a_pos_valid && pos <= last_a_pos)
                     : (b_pos_valid && pos <= last_b_pos);
    bad_full  = is_a ? (a_count >= CntW'(MaxNnz)) : (b_count >= CntW'(MaxNnz));
  end

  // Result of an item that answers straight from the idle state.
  result_t idle_res;
  always_comb begin
    idle_res = '0;
    unique case (item.kind)
      KIND_LOAD_A, KIND_LOAD_B: begin
        if (bad_range)      idle_res.status = ST_RANGE;
        else if (bad_order) idle_res.status = ST_ORDER;
        else if (bad_full)  idle_res.status = ST_FULL;
      end
      KIND_RUN: begin
        if ({1'b0, item.row} >= nr) idle_res.status = ST_RANGE;
      end
      default: ;
    endcase
  end

  // Start of A row k: rows past the last loaded row all start at a_count.
  logic [DimW-1:0] rs_k;
  logic [CntW-1:0] a_start_sel;
  always_comb begin
    rs_k        = (state == S_RS1) ? {1'b0, run_row} : DimW'(run_row) + DimW'(1);
    a_start_sel = (a_pos_valid && rs_k <= {1'b0, last_a_pos[2*IdxW-1:IdxW]})
                  ? a_start_rd : a_count;
  end

  // Read addresses.
  logic [DimW-1:0] a_start_addr, bt_start_addr;
  assign a_start_addr  = (state == S_RS0) ? {1'b0, run_row}
                                          : DimW'(run_row) + DimW'(1);
  assign bt_start_addr = (state == S_COL0) ? {1'b0, col_j}
                                           : DimW'(col_j) + DimW'(1);

  always_ff @(posedge clk) begin
    a_val_rd    <= a_val_mem[pa[AddrW-1:0]];
    a_col_rd    <= a_col_mem[pa[AddrW-1:0]];
    bt_val_rd   <= bt_val_mem[pb[AddrW-1:0]];
    bt_row_rd   <= bt_row_mem[pb[AddrW-1:0]];
    b_val_rd    <= b_val_mem[tr_i[AddrW-1:0]];
    b_row_rd    <= b_row_mem[tr_i[AddrW-1:0]];
    b_col_rd    <= b_col_mem[tr_i[AddrW-1:0]];
    a_start_rd  <= a_start_mem[a_start_addr];
    bt_start_rd <= bt_start_mem[bt_start_addr];
  end

  // Memory writes.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid && !bad_range && !bad_order && !bad_full) begin
      if (item.kind == KIND_LOAD_A) begin
        a_val_mem[a_count[AddrW-1:0]] <= item.value;
        a_col_mem[a_count[AddrW-1:0]] <= item.col;
      end else if (item.kind == KIND_LOAD_B) begin
        b_val_mem[b_count[AddrW-1:0]] <= item.value;
        b_row_mem[b_count[AddrW-1:0]] <= item.row;
        b_col_mem[b_count[AddrW-1:0]] <= item.col;
      end
    end
    if (state == S_AFILL) begin
      a_start_mem[fill_k] <= fill_v;
    end
    if (state == S_TR_COL) begin
      bt_start_mem[tr_col] <= tr_wp;
    end
    if (state == S_TR_CHK && b_col_rd == tr_col[IdxW-1:0]) begin
      bt_val_mem[tr_wp[AddrW-1:0]] <= b_val_rd;
      bt_row_mem[tr_wp[AddrW-1:0]] <= b_row_rd;
    end
  end

  // Saturating accumulate of one product.
  logic signed [SumW:0] acc_wide;
  logic signed [SumW-1:0] acc_sat;
  always_comb begin
    acc_wide = {sum[SumW-1], sum} + (SumW+1)'(prod);
    if (acc_wide > SumMax)      acc_sat = SumMax[SumW-1:0];
    else if (acc_wide < SumMin) acc_sat = SumMin[SumW-1:0];
    else                        acc_sat = acc_wide[SumW-1:0];
  end

  logic nz, cend_block, last_col;
  assign nz         = (sum != '0);
  assign cend_block = nz && have_held && result_valid;
  assign last_col   = ({1'b0, col_j} == nc - DimW'(1));

  // Entry for the column just finished, or the empty-row marker.
  result_t col_res;
  always_comb begin
    col_res         = '0;
    col_res.out_row = run_row;
    if (nz) begin
      col_res.out_col   = col_j;
      col_res.out_value = sum;
    end else begin
      col_res.empty_res = 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        res <= idle_res;
        if (item_valid) begin
          run_row  <= item.row;
          fill_end <= item.row;
          fill_v   <= a_count;
          fill_k   <= a_pos_valid ? DimW'(last_a_pos[2*IdxW-1:IdxW]) + DimW'(1) : '0;
        end
      end
      S_AFILL: fill_k <= fill_k + DimW'(1);
      S_RS1:   a_beg <= a_start_sel;
      S_RS2:   a_end <= a_start_sel;
      S_COL1:  pb <= bt_start_rd;
      S_COL2: begin
        b_end <= bt_start_rd;
        pa    <= a_beg;
        sum   <= '0;
      end
      S_MCMP: begin
        if (a_col_rd == bt_row_rd) begin
          prod <= a_val_rd * bt_val_rd;
          pa   <= pa + CntW'(1);
          pb   <= pb + CntW'(1);
        end else if (a_col_rd < bt_row_rd) begin
          pa <= pa + CntW'(1);
        end else begin
          pb <= pb + CntW'(1);
        end
      end
      S_MACC: sum <= acc_sat;
      S_CEND: begin
        if (!cend_block && (nz || (last_col && !have_held))) res <= col_res;
      end
      default: ;
    endcase
  end

  // The final result of an item carries the last flag.
  result_t res_final;
  always_comb begin
    res_final      = res;
    res_final.last = 1'b1;
  end

  // Output register: the result slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) result_valid <= 1'b0;
      if (state == S_EMIT && !result_valid) begin
        result_valid <= 1'b1;
      end else if (state == S_CEND && nz && have_held && !result_valid) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && !result_valid) begin
      result <= res_final;
    end else if (state == S_CEND && nz && have_held && !result_valid) begin
      result <= res;
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      a_rows          <= DimW'(MaxDim);
      inner_dim       <= DimW'(MaxDim);
      b_cols          <= DimW'(MaxDim);
      a_count         <= '0;
      b_count         <= '0;
      a_pos_valid     <= 1'b0;
      b_pos_valid     <= 1'b0;
      last_a_pos      <= '0;
      last_b_pos      <= '0;
      transpose_ready <= 1'b0;
      tr_col          <= '0;
      tr_i            <= '0;
      tr_wp           <= '0;
      col_j           <= '0;
      have_held       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_A_ROWS:    a_rows    <= cfg_data;
          CFG_INNER_DIM: inner_dim <= cfg_data;
          CFG_B_COLS:    b_cols    <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            unique case (item.kind)
              KIND_LOAD_A: begin
                if (!bad_range && !bad_order && !bad_full) begin
                  a_count     <= a_count + CntW'(1);
                  a_pos_valid <= 1'b1;
                  last_a_pos  <= pos;
                  if (!a_pos_valid || item.row != last_a_pos[2*IdxW-1:IdxW]) begin
                    state <= S_AFILL;
                  end else begin
                    state <= S_EMIT;
                  end
                end else begin
                  state <= S_EMIT;
                end
              end
              KIND_LOAD_B: begin
                state <= S_EMIT;
                if (!bad_range && !bad_order && !bad_full) begin
                  b_count         <= b_count + CntW'(1);
                  b_pos_valid     <= 1'b1;
                  last_b_pos      <= pos;
                  transpose_ready <= 1'b0;
                end
              end
              KIND_RUN: begin
                have_held <= 1'b0;
                col_j     <= '0;
                if ({1'b0, item.row} < nr) begin
                  if (transpose_ready) begin
                    state <= S_RS0;
                  end else begin
                    state  <= S_TR_COL;
                    tr_col <= '0;
                    tr_wp  <= '0;
                  end
                end else begin
                  state <= S_EMIT;
                end
              end
              KIND_CLEAR: begin
                state           <= S_EMIT;
                a_count         <= '0;
                b_count         <= '0;
                a_pos_valid     <= 1'b0;
                b_pos_valid     <= 1'b0;
                last_a_pos      <= '0;
                last_b_pos      <= '0;
                transpose_ready <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_AFILL: begin
          if (fill_k == {1'b0, fill_end}) state <= S_EMIT;
        end
        S_EMIT: begin
          if (!result_valid) state <= S_IDLE;
        end
        // Build the column copy of B one column at a time.
        S_TR_COL: begin
          tr_i <= '0;
          if (tr_col == DimW'(MaxDim)) begin
            transpose_ready <= 1'b1;
            state           <= S_RS0;
          end else if (b_count == '0) begin
            tr_col <= tr_col + DimW'(1);
          end else begin
            state <= S_TR_RD;
          end
        end
        S_TR_RD: state <= S_TR_CHK;
        S_TR_CHK: begin
          if (b_col_rd == tr_col[IdxW-1:0]) tr_wp <= tr_wp + CntW'(1);
          if (tr_i + CntW'(1) == b_count) begin
            tr_col <= tr_col + DimW'(1);
            state  <= S_TR_COL;
          end else begin
            tr_i  <= tr_i + CntW'(1);
            state <= S_TR_RD;
          end
        end
        S_RS0:  state <= S_RS1;
        S_RS1:  state <= S_RS2;
        S_RS2:  state <= S_COL0;
        S_COL0: state <= S_COL1;
        S_COL1: state <= S_COL2;
        S_COL2: state <= S_MRD;
        S_MRD: begin
          if (pa < a_end && pb < b_end) state <= S_MCMP;
          else                          state <= S_CEND;
        end
        S_MCMP: begin
          if (a_col_rd == bt_row_rd) state <= S_MACC;
          else                       state <= S_MRD;
        end
        S_MACC: state <= S_MRD;
        S_CEND: begin
          if (!cend_block) begin
            if (nz) have_held <= 1'b1;
            if (last_col) begin
              state <= S_EMIT;
            end else begin
              col_j <= col_j + IdxW'(1);
              state <= S_COL0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> verif/tb_sparse_csr_matrix_multiply_top.sv
// ----------------------------------------------------------------------------
// Testbench for the sparse matrix multiplier
// Loads sparse A and B matrices through the item channel, runs rows of C and
// checks every result transaction against a predictor kept inside the bench.
// The shape registers change between phases, and both handshake sides stall.
// ----------------------------------------------------------------------------
module tb_sparse_csr_matrix_multiply_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sccm_pkg::*;

  localparam int CycleLimit = 2_000_000;
  localparam int ItemTarget = 310;
  localparam longint SumMax = 64'sd549755813887;
  localparam longint SumMin = -64'sd549755813888;
  // A register index past the end of the register list.
  localparam logic [CfgIdxW-1:0] CfgNoReg = 2'd3;

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_ready;
  item_t               item_bus;
  logic                result_valid;
  logic                result_ready;
  result_t             result_bus;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [DimW-1:0]     cfg_data;

  sparse_csr_matrix_multiply_top DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_bus),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_bus),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Stimulus and checking state.
  item_t   pending_items[$];
  result_t expected_results[$];
  int      error_count;
  int      cycle_count;
  int      items_queued;
  int      items_taken;
  int      results_seen;
  int      row_runs;
  int      rejected_loads;
  int      send_idle_pct;
  int      recv_idle_pct;
  bit      item_taken;
  bit      hold_request;
  int      hold_left;

  // Predictor copy of the block: shape registers and both entry stores.
  int      shape_rows, shape_inner, shape_cols;
  longint  a_val[MaxNnz];
  int      a_col[MaxNnz];
  int      a_start[MaxDim+1];
  longint  b_val[MaxNnz];
  int      b_row[MaxNnz];
  int      b_col[MaxNnz];
  longint  bt_val[MaxNnz];
  int      bt_row[MaxNnz];
  int      bt_start[MaxDim+1];
  int      a_cnt, b_cnt;
  int      a_last, b_last;
  bit      a_seen, b_seen;
  bit      bt_valid;

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Register values are used clamped to 1..MaxDim.
  function automatic int clamp_dim(int v);
    if (v < 1) return 1;
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  function automatic void empty_stores();
    for (int i = 0; i <= MaxDim; i++) begin
      a_start[i] = 0;
      bt_start[i] = 0;
    end
    a_cnt = 0;
    b_cnt = 0;
    a_last = 0;
    b_last = 0;
    a_seen = 1'b0;
    b_seen = 1'b0;
    bt_valid = 1'b0;
  endfunction

  function automatic void push_result(status_t st, int r, int c, longint v, bit lst,
                                      bit emp);
    result_t res;
    res.status    = st;
    res.out_row   = r[IdxW-1:0];
    res.out_col   = c[IdxW-1:0];
    res.out_value = v[SumW-1:0];
    res.last      = lst;
    res.empty_res = emp;
    expected_results = {expected_results, res};
  endfunction

  // Column-major copy of B, rebuilt on the first row run after B changed.
  function automatic void rebuild_columns();
    int fill[MaxDim];
    for (int c = 0; c <= MaxDim; c++) bt_start[c] = 0;
    for (int i = 0; i < b_cnt; i++) bt_start[b_col[i] + 1]++;
    for (int c = 0; c < MaxDim; c++) bt_start[c + 1] += bt_start[c];
    for (int c = 0; c < MaxDim; c++) fill[c] = bt_start[c];
    for (int i = 0; i < b_cnt; i++) begin
      bt_val[fill[b_col[i]]] = b_val[i];
      bt_row[fill[b_col[i]]] = b_row[i];
      fill[b_col[i]]++;
    end
    bt_valid = 1'b1;
  endfunction

  // Dot product of A row r with B column c, saturated after each addition.
  function automatic longint row_col_sum(int r, int c);
    int pa, ea, pb, eb;
    longint acc;
    pa = a_start[r];
    ea = a_start[r + 1];
    pb = bt_start[c];
    eb = bt_start[c + 1];
    acc = 0;
    while (pa < ea && pb < eb) begin
      if (a_col[pa] == bt_row[pb]) begin
        acc += a_val[pa] * bt_val[pb];
        if (acc > SumMax) acc = SumMax;
        if (acc < SumMin) acc = SumMin;
        pa++;
        pb++;
      end else if (a_col[pa] < bt_row[pb]) begin
        pa++;
      end else begin
        pb++;
      end
    end
    return acc;
  endfunction

  // Works out the results that one accepted item causes.
  function automatic void predict_item(item_t it);
    int nr, nk, nc, r, c, pos, found;
    bit is_a;
    longint v, s;
    nr = clamp_dim(shape_rows);
    nk = clamp_dim(shape_inner);
    nc = clamp_dim(shape_cols);
    r = it.row;
    c = it.col;
    v = longint'(it.value);
    pos = r * MaxDim + c;
    case (kind_t'(it.kind))
      KIND_LOAD_A, KIND_LOAD_B: begin
        is_a = (kind_t'(it.kind) == KIND_LOAD_A);
        if (r >= (is_a ? nr : nk) || c >= (is_a ? nk : nc)) begin
          push_result(ST_RANGE, 0, 0, 0, 1'b1, 1'b0);
          rejected_loads++;
        end else if (is_a ? (a_seen && pos <= a_last) : (b_seen && pos <= b_last)) begin
          push_result(ST_ORDER, 0, 0, 0, 1'b1, 1'b0);
          rejected_loads++;
        end else if ((is_a ? a_cnt : b_cnt) >= MaxNnz) begin
          push_result(ST_FULL, 0, 0, 0, 1'b1, 1'b0);
          rejected_loads++;
        end else begin
          if (is_a) begin
            a_val[a_cnt] = v;
            a_col[a_cnt] = c;
            a_cnt++;
            for (int k = r + 1; k <= MaxDim; k++) a_start[k]++;
            a_last = pos;
            a_seen = 1'b1;
          end else begin
            b_val[b_cnt] = v;
            b_row[b_cnt] = r;
            b_col[b_cnt] = c;
            b_cnt++;
            b_last = pos;
            b_seen = 1'b1;
            bt_valid = 1'b0;
          end
          push_result(ST_OK, 0, 0, 0, 1'b1, 1'b0);
        end
      end
      KIND_CLEAR: begin
        empty_stores();
        push_result(ST_OK, 0, 0, 0, 1'b1, 1'b0);
      end
      default: begin
        row_runs++;
        if (r >= nr) begin
          push_result(ST_RANGE, 0, 0, 0, 1'b1, 1'b0);
        end else begin
          if (!bt_valid) rebuild_columns();
          found = 0;
          for (int j = 0; j < nc; j++) begin
            s = row_col_sum(r, j);
            if (s != 0) begin
              push_result(ST_OK, r, j, s, 1'b0, 1'b0);
              found++;
            end
          end
          if (found == 0) push_result(ST_OK, r, 0, 0, 1'b1, 1'b1);
          else expected_results[$].last = 1'b1;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("ERROR cycle %0d: result field %s got %0d expected %0d",
             cycle_count, field, got, want);
    error_count++;
  endtask

  task automatic check_result(result_t got, result_t want);
    if (got.status != want.status) report_mismatch("status", got.status, want.status);
    if (got.out_row != want.out_row) report_mismatch("out_row", got.out_row, want.out_row);
    if (got.out_col != want.out_col) report_mismatch("out_col", got.out_col, want.out_col);
    if (got.out_value != want.out_value)
      report_mismatch("out_value", longint'(got.out_value), longint'(want.out_value));
    if (got.last != want.last) report_mismatch("last", got.last, want.last);
    if (got.empty_res != want.empty_res)
      report_mismatch("empty_res", got.empty_res, want.empty_res);
  endtask

  // Sample both handshakes at the rising edge. An accepted item updates the
  // predictor right away, so expectations always lead the results.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
    item_taken <= item_valid && item_ready && !rst;
    if (!rst && item_valid && item_ready) begin
      predict_item(item_bus);
      items_taken++;
    end
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected", 0, 0);
      end else begin
        check_result(result_bus, expected_results.pop_front());
      end
    end
  end

  // Item driver: a new transaction is offered only once the previous one
  // has been taken, and a held item never changes.
  always @(negedge clk) begin
    if (!rst && (!item_valid || item_taken)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item_bus <= pending_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when requested. The
  // hold-off is counted here so that the item driver keeps offering work.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = 600;
      hold_request = 1'b0;
    end
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_item(kind_t k, int r, int c, int v);
    item_t it;
    it.kind  = k;
    it.row   = r[IdxW-1:0];
    it.col   = c[IdxW-1:0];
    it.value = v[ValW-1:0];
    pending_items = {pending_items, it};
    items_queued++;
  endtask

  // Waits until every queued transaction was taken and answered, plus a
  // short settling margin, so the block is idle.
  task automatic wait_idle();
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Register write, made only while the block is idle.
  task automatic write_shape(logic [CfgIdxW-1:0] idx, int v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v[DimW-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_A_ROWS:    shape_rows  = v & 63;
      CFG_INNER_DIM: shape_inner = v & 63;
      CFG_B_COLS:    shape_cols  = v & 63;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all_shapes(int r, int k, int c);
    write_shape(CFG_A_ROWS, r);
    write_shape(CFG_INNER_DIM, k);
    write_shape(CFG_B_COLS, c);
  endtask

  // One well-formed session: clear, sorted A and B entries with random
  // values, then row runs. Now and then a stray load breaks the ordering.
  task automatic add_session();
    int nr, nk, nc, per_mille;
    nr = clamp_dim(shape_rows);
    nk = clamp_dim(shape_inner);
    nc = clamp_dim(shape_cols);
    add_item(KIND_CLEAR, $urandom_range(31), $urandom_range(31), $urandom);
    per_mille = $urandom_range(1, 6) * 1000 / (nr * nk);
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nk; c++)
        if ($urandom_range(999) < per_mille) begin
          add_item(KIND_LOAD_A, r, c, $urandom);
          if ($urandom_range(24) == 0)
            add_item(kind_t'($urandom_range(1)), $urandom_range(31), $urandom_range(31),
                     $urandom);
        end
    per_mille = $urandom_range(1, 6) * 1000 / (nk * nc);
    for (int r = 0; r < nk; r++)
      for (int c = 0; c < nc; c++)
        if ($urandom_range(999) < per_mille) begin
          add_item(KIND_LOAD_B, r, c, $urandom);
          if ($urandom_range(24) == 0)
            add_item(kind_t'($urandom_range(1)), $urandom_range(31), $urandom_range(31),
                     $urandom);
        end
    repeat ($urandom_range(2, 6))
      add_item(KIND_RUN, ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(nr - 1),
               $urandom_range(31), $urandom);
  endtask

  initial begin
    int sessions_left;
    int base_items;
    bit hold_done;
    rst          = 1'b1;
    item_valid   = 1'b0;
    item_bus     = '0;
    result_ready = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_A_ROWS;
    cfg_data     = '0;
    hold_request = 1'b0;
    hold_left    = 0;
    hold_done    = 1'b0;
    item_taken   = 1'b0;
    error_count  = 0;
    cycle_count  = 0;
    shape_rows   = MaxDim;
    shape_inner  = MaxDim;
    shape_cols   = MaxDim;
    empty_stores();
    send_idle_pct = 8;
    recv_idle_pct = 85;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset shape: extreme values and corners, order
    // violations, a row with no nonzero sum and the full 32-column width.
    add_item(KIND_CLEAR, 31, 31, 16'hFFFF);
    add_item(KIND_LOAD_A, 0, 0, 16'h7FFF);
    add_item(KIND_LOAD_A, 0, 31, 16'h8000);
    add_item(KIND_LOAD_A, 0, 5, 1);          // behind the last A entry
    add_item(KIND_LOAD_A, 31, 31, 16'hFFFF);
    add_item(KIND_LOAD_A, 31, 31, 2);        // same position again
    add_item(KIND_LOAD_B, 0, 0, 16'h8000);
    add_item(KIND_LOAD_B, 0, 31, 16'h0100);
    add_item(KIND_LOAD_B, 31, 0, 16'h7FFF);
    add_item(KIND_LOAD_B, 31, 31, 16'h0001);
    add_item(KIND_LOAD_B, 5, 3, 16'h1234);   // out of order in B
    add_item(KIND_RUN, 0, 31, 16'hFFFF);
    add_item(KIND_RUN, 5, 0, 0);             // row without entries
    add_item(KIND_RUN, 31, 0, 0);
    wait_idle();
    // Small shape: range checks on both stores and on the row run, with
    // entries loaded earlier now lying outside the shape.
    write_all_shapes(2, 3, 2);
    add_item(KIND_LOAD_A, 2, 0, 7);          // row beyond a_rows
    add_item(KIND_LOAD_A, 1, 3, 7);          // column beyond inner_dim
    add_item(KIND_LOAD_B, 3, 0, 7);          // row beyond inner_dim
    add_item(KIND_LOAD_B, 0, 2, 7);          // column beyond b_cols
    add_item(KIND_RUN, 2, 0, 0);             // row beyond a_rows
    add_item(KIND_RUN, 0, 0, 0);
    wait_idle();
    // Out-of-range register values clamp; an index past the list is ignored.
    write_all_shapes(0, 63, 0);
    write_shape(CfgNoReg, 5);
    add_item(KIND_LOAD_A, 1, 0, 3);
    add_item(KIND_RUN, 0, 0, 0);
    add_item(KIND_RUN, 1, 0, 0);
    wait_idle();

    // Fill the A store to the last slot and beyond, then run full rows
    // against a few B entries.
    write_all_shapes(63, 32, 32);
    add_item(KIND_CLEAR, 0, 0, 0);
    for (int i = 0; i <= MaxNnz; i++) add_item(KIND_LOAD_A, i / 32, i % 32, $urandom);
    for (int i = 0; i < 4; i++) add_item(KIND_LOAD_B, i * 8, i * 8 + 1, $urandom);
    add_item(KIND_RUN, 0, 0, 0);
    add_item(KIND_RUN, 7, 0, 0);
    wait_idle();

    // Random part in three idling phases: sender busy with receiver
    // stalling, then the reverse, then full speed with one long hold-off.
    base_items = items_queued;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 85 : 0;
      recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 8 : 0;
      sessions_left = 1;
      while (sessions_left > 0) begin
        case ($urandom_range(4))
          0:       write_all_shapes(MaxDim, MaxDim, MaxDim);
          1:       write_all_shapes(1, $urandom_range(1, 4), $urandom_range(1, 4));
          default: write_all_shapes($urandom_range(1, 32), $urandom_range(1, 32),
                                    $urandom_range(1, 32));
        endcase
        if (phase == 2 && !hold_done) begin
          hold_request = 1'b1;
          hold_done    = 1'b1;
        end
        add_session();
        wait_idle();
        sessions_left = (items_queued < base_items +
                         (ItemTarget - base_items) * (phase + 1) / 3) ? 1 : 0;
      end
    end

    wait_idle();
    repeat (100) @(posedge clk);
    $display("Covered %0d item transactions, %0d row runs, %0d rejected loads,",
             items_taken, row_runs, rejected_loads);
    $display("and checked %0d result transactions over several matrix shapes.",
             results_seen);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
